// File: rtl/msss_pkg.sv
// ----------------------------------------------------------------------------
// Minimum vertical seam search: shared types and constants
// Field widths, move and opcode encodings, sequencer states and the
// records used by the cost unit and the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package msss_pkg;

	localparam int CostW    = 32;
	localparam int EnergyW  = 16;
	localparam int CfgW     = 10;
	localparam int RowOutW  = 9;
	localparam int ColOutW  = 9;
	localparam int InDataW  = 16;
	localparam int OutDataW = 24;

	localparam logic REG_FRAME_WIDTH  = 1'b0;
	localparam logic REG_FRAME_HEIGHT = 1'b1;

	typedef enum logic {
		OP_LOAD = 1'b0,
		OP_SEAM = 1'b1
	} op_t;

	typedef enum logic {
		PH_LOAD  = 1'b0,
		PH_TRACE = 1'b1
	} phase_t;

	typedef enum logic [1:0] {
		MV_UP    = 2'd0,
		MV_LEFT  = 2'd1,
		MV_RIGHT = 2'd2
	} move_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_COL0,
		ST_CALC,
		ST_TRACE,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [CostW-1:0] cost;
		move_t            mv;
	} dp_res_t;

	typedef struct packed {
		logic               valid_res;
		logic [RowOutW-1:0] seam_row;
		logic [ColOutW-1:0] seam_col;
		logic               last;
	} seam_res_t;

endpackage

`default_nettype wire

// File: rtl/msss_ram.sv
// ----------------------------------------------------------------------------
// Minimum vertical seam search: simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module msss_ram #(
	parameter int DATA_W = 32,
	parameter int DEPTH  = 512
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [DATA_W-1:0]        wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [DATA_W-1:0]        rd_data
);

	logic [DATA_W-1:0] mem [DEPTH];
	logic [DATA_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

// File: rtl/msss_dp_cell.sv
// ----------------------------------------------------------------------------
// Minimum vertical seam search: cost cell
// Picks the cheapest of the three upper neighbors and adds the cell energy
// with saturation; on the first row the cost is the cell energy alone.
// ----------------------------------------------------------------------------
`default_nettype none

module msss_dp_cell (
	input  wire logic [msss_pkg::CostW-1:0]   left,
	input  wire logic [msss_pkg::CostW-1:0]   mid,
	input  wire logic [msss_pkg::CostW-1:0]   right,
	input  wire logic                         left_ok,
	input  wire logic                         right_ok,
	input  wire logic                         first_row,
	input  wire logic [msss_pkg::EnergyW-1:0] energy,
	output msss_pkg::dp_res_t                 res
);

	import msss_pkg::*;

	logic [CostW-1:0] best;
	move_t            best_mv;
	logic [CostW:0]   sum;

	// Ties keep the center, then the left neighbor, then the right one.
	always_comb begin
		best    = mid;
		best_mv = MV_UP;
		if (left_ok && (left < best)) begin
			best    = left;
			best_mv = MV_LEFT;
		end
		if (right_ok && (right < best)) begin
			best    = right;
			best_mv = MV_RIGHT;
		end
	end

	assign sum = {1'b0, best} + (CostW+1)'(energy);

	always_comb begin
		if (first_row) begin
			res.cost = CostW'(energy);
			res.mv   = MV_UP;
		end else begin
			res.cost = sum[CostW] ? {CostW{1'b1}} : sum[CostW-1:0];
			res.mv   = best_mv;
		end
	end

endmodule

`default_nettype wire

// File: rtl/min_vertical_seam_search.sv
// ----------------------------------------------------------------------------
// Minimum vertical seam search
// Row-by-row seam cost accumulation with parent moves and seam trace-back.
// ----------------------------------------------------------------------------
// The slave stream carries one item per transfer: tuser is the opcode, tdata
// the cell energy. Load items stream the energy of a frame in row-major
// order; once the last cell is in, seam requests return the seam one row
// per transfer, bottom row first, with tlast on the top row.
// Every accepted item gives exactly one master transfer; tuser low marks an
// acknowledge with no seam entry and zero data.
// A load item passes through the calculate state, after a column-zero state
// at column zero of every row after the first; a seam request passes through
// the trace state, except the top-row entry that ends the seam; items in the
// wrong phase go straight to the done state. The steps follow the registered
// reads of the row cost and parent move memories, each in read-compute-write
// sequences; the last-row minimum is tracked as the row arrives.
// The result sits in an output register, so a stalled receiver holds only
// that register; the next item is taken and worked on, then waits for it.
// Reset clears the counters and returns the block to loading with a
// 512 by 512 frame (clamped to the maximum size); the memories are not
// cleared. A configuration write restarts the frame.
// ----------------------------------------------------------------------------
`default_nettype none

module min_vertical_seam_search #(
	parameter int MAX_WIDTH  = 512,
	parameter int MAX_HEIGHT = 512
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	input  wire logic [msss_pkg::InDataW-1:0]  s_tdata,   // [15:0] cell_energy
	input  wire logic                          s_tuser,   // [0] op
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	output logic      [msss_pkg::OutDataW-1:0] m_tdata,   // [8:0] seam_row, [17:9] seam_col
	output logic                               m_tuser,   // [0] valid_res
	output logic                               m_tlast,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic                          cfg_index,
	input  wire logic [msss_pkg::CfgW-1:0]     cfg_data
);

	import msss_pkg::*;

	localparam int CW        = $clog2(MAX_WIDTH);
	localparam int RW        = $clog2(MAX_HEIGHT);
	localparam int MoveDepth = MAX_HEIGHT * (2 ** CW);
	localparam int RstW      = (MAX_WIDTH < 512) ? MAX_WIDTH : 512;
	localparam int RstH      = (MAX_HEIGHT < 512) ? MAX_HEIGHT : 512;

	state_t state_q, state_n;
	phase_t phase_q;

	logic [CW-1:0]    last_col_q;
	logic [RW-1:0]    last_row_q;
	logic [CW-1:0]    load_col_q;
	logic [RW-1:0]    load_row_q;
	logic [CW-1:0]    trace_col_q;
	logic [RW-1:0]    trace_row_q;
	logic [EnergyW-1:0] e_q;
	logic [CostW-1:0] left_q;
	logic [CostW-1:0] mid_q;
	logic [CostW-1:0] min_cost_q;
	logic [CW-1:0]    min_col_q;
	seam_res_t        pend_q;
	seam_res_t        out_q;
	logic             m_tvalid_q;

	logic             accept;
	op_t              op;
	logic             cfg_write;
	logic [31:0]      cfg_val32;
	logic [CW-1:0]    cfg_last_col;
	logic [RW-1:0]    cfg_last_row;

	logic             cost_rd_en;
	logic [CW-1:0]    cost_rd_addr;
	logic [CostW-1:0] cost_rd_data;
	logic             cost_wr_en;
	logic             mv_rd_en;
	logic [1:0]       mv_rd_data;
	logic             mv_wr_en;
	logic             out_load;

	dp_res_t          dp_res;
	logic             new_min;
	move_t            trace_mv;

	assign op        = op_t'(s_tuser);
	assign accept    = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;
	assign cfg_write = cfg_valid && cfg_ready;
	assign cfg_val32 = 32'(cfg_data);

	always_comb begin
		if (cfg_val32 == 32'd0) begin
			cfg_last_col = '0;
			cfg_last_row = '0;
		end else begin
			cfg_last_col = (cfg_val32 > 32'(MAX_WIDTH)) ? CW'(MAX_WIDTH - 1) :
				CW'(cfg_val32 - 32'd1);
			cfg_last_row = (cfg_val32 > 32'(MAX_HEIGHT)) ? RW'(MAX_HEIGHT - 1) :
				RW'(cfg_val32 - 32'd1);
		end
	end

	msss_ram #(
		.DATA_W(CostW),
		.DEPTH (MAX_WIDTH)
	) u_cost_ram (
		.clk    (clk),
		.wr_en  (cost_wr_en),
		.wr_addr(load_col_q),
		.wr_data(dp_res.cost),
		.rd_en  (cost_rd_en),
		.rd_addr(cost_rd_addr),
		.rd_data(cost_rd_data)
	);

	msss_ram #(
		.DATA_W(2),
		.DEPTH (MoveDepth)
	) u_move_ram (
		.clk    (clk),
		.wr_en  (mv_wr_en),
		.wr_addr({load_row_q, load_col_q}),
		.wr_data(dp_res.mv),
		.rd_en  (mv_rd_en),
		.rd_addr({trace_row_q, trace_col_q}),
		.rd_data(mv_rd_data)
	);

	msss_dp_cell u_dp_cell (
		.left     (left_q),
		.mid      (mid_q),
		.right    (cost_rd_data),
		.left_ok  (load_col_q != '0),
		.right_ok (load_col_q != last_col_q),
		.first_row(load_row_q == '0),
		.energy   (e_q),
		.res      (dp_res)
	);

	assign new_min  = (load_col_q == '0) || (dp_res.cost < min_cost_q);
	assign trace_mv = move_t'(mv_rd_data);

	always_comb begin
		state_n = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (op == OP_LOAD && phase_q == PH_LOAD) begin
						state_n = (load_row_q != '0 && load_col_q == '0) ? ST_COL0 : ST_CALC;
					end else if (op == OP_SEAM && phase_q == PH_TRACE &&
						trace_row_q != '0) begin
						state_n = ST_TRACE;
					end else begin
						state_n = ST_DONE;
					end
				end
			end
			ST_COL0:  state_n = ST_CALC;
			ST_CALC:  state_n = ST_DONE;
			ST_TRACE: state_n = ST_DONE;
			ST_DONE:  state_n = out_load ? ST_IDLE : ST_DONE;
			default:  state_n = ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready     = 1'b0;
		cost_rd_en   = 1'b0;
		cost_rd_addr = '0;
		cost_wr_en   = 1'b0;
		mv_rd_en     = 1'b0;
		mv_wr_en     = 1'b0;
		out_load     = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid && op == OP_LOAD && phase_q == PH_LOAD && load_row_q != '0) begin
					if (load_col_q == '0) begin
						cost_rd_en = 1'b1;
					end else begin
						cost_rd_en   = (load_col_q != last_col_q);
						cost_rd_addr = load_col_q + CW'(1);
					end
				end
				if (s_tvalid && op == OP_SEAM && phase_q == PH_TRACE && trace_row_q != '0) begin
					mv_rd_en = 1'b1;
				end
			end
			ST_COL0: begin
				cost_rd_en   = (last_col_q != '0);
				cost_rd_addr = CW'(1);
			end
			ST_CALC: begin
				cost_wr_en = 1'b1;
				mv_wr_en   = (load_row_q != '0);
			end
			ST_DONE: begin
				out_load = !m_tvalid_q || m_tready;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			phase_q     <= PH_LOAD;
			last_col_q  <= CW'(RstW - 1);
			last_row_q  <= RW'(RstH - 1);
			load_col_q  <= '0;
			load_row_q  <= '0;
			trace_col_q <= '0;
			trace_row_q <= '0;
			m_tvalid_q  <= 1'b0;
		end else begin
			state_q <= state_n;

			if (state_q == ST_IDLE && accept && op == OP_SEAM && phase_q == PH_TRACE &&
				trace_row_q == '0) begin
				phase_q     <= PH_LOAD;
				load_col_q  <= '0;
				load_row_q  <= '0;
				trace_col_q <= '0;
			end

			if (state_q == ST_CALC) begin
				if (load_col_q == last_col_q) begin
					load_col_q <= '0;
					if (load_row_q == last_row_q) begin
						load_row_q  <= '0;
						phase_q     <= PH_TRACE;
						trace_row_q <= last_row_q;
						trace_col_q <= new_min ? load_col_q : min_col_q;
					end else begin
						load_row_q <= load_row_q + RW'(1);
					end
				end else begin
					load_col_q <= load_col_q + CW'(1);
				end
			end

			if (state_q == ST_TRACE) begin
				if (trace_mv == MV_LEFT && trace_col_q != '0) begin
					trace_col_q <= trace_col_q - CW'(1);
				end else if (trace_mv == MV_RIGHT && trace_col_q != last_col_q) begin
					trace_col_q <= trace_col_q + CW'(1);
				end
				trace_row_q <= trace_row_q - RW'(1);
			end

			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end

			if (cfg_write) begin
				if (cfg_index == REG_FRAME_WIDTH) begin
					last_col_q <= cfg_last_col;
				end else begin
					last_row_q <= cfg_last_row;
				end
				phase_q     <= PH_LOAD;
				load_col_q  <= '0;
				load_row_q  <= '0;
				trace_col_q <= '0;
				trace_row_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && accept) begin
			e_q <= s_tdata[EnergyW-1:0];
			if (op == OP_SEAM && phase_q == PH_TRACE) begin
				pend_q.valid_res <= 1'b1;
				pend_q.seam_row  <= RowOutW'(trace_row_q);
				pend_q.seam_col  <= ColOutW'(trace_col_q);
				pend_q.last      <= (trace_row_q == '0);
			end else begin
				pend_q <= '0;
			end
		end
		if (state_q == ST_COL0) begin
			mid_q <= cost_rd_data;
		end
		if (state_q == ST_CALC) begin
			left_q <= mid_q;
			mid_q  <= cost_rd_data;
			if (load_row_q == last_row_q && new_min) begin
				min_cost_q <= dp_res.cost;
				min_col_q  <= load_col_q;
			end
		end
		if (out_load) begin
			out_q <= pend_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = OutDataW'({out_q.seam_col, out_q.seam_row});
	assign m_tuser  = out_q.valid_res;
	assign m_tlast  = out_q.last;

endmodule

`default_nettype wire

// File: rtl/msss_checker.sv
// ----------------------------------------------------------------------------
// Minimum vertical seam search: port checker
// Checks the result stream and the input pacing seen at the top-level ports.
// ----------------------------------------------------------------------------
`default_nettype none

module msss_checker (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          s_tvalid,
	input wire logic                          s_tready,
	input wire logic                          m_tvalid,
	input wire logic                          m_tready,
	input wire logic [msss_pkg::OutDataW-1:0] m_tdata,
	input wire logic                          m_tuser,
	input wire logic                          m_tlast
);

	// The input is never ready in the cycle after an item is accepted.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input accepted in back-to-back cycles");

	a_last_on_top_row: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> m_tuser && (m_tdata[8:0] == 9'd0))
		else $error("final seam entry not on the top row");

	a_ack_is_empty: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> (m_tdata == '0) && !m_tlast)
		else $error("acknowledge carries seam data");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser) &&
			$stable(m_tlast))
		else $error("stalled result transfer changed");

endmodule

bind min_vertical_seam_search msss_checker u_msss_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata),
	.m_tuser (m_tuser),
	.m_tlast (m_tlast)
);

`default_nettype wire
